[rtl/core/bgpe_pkg.sv]
// Shared types and constants of the bitmap glyph pixel expander.
// Used by every module in rtl/core; depends on nothing.
package bgpe_pkg;

  localparam int MAX_FONT_WIDTH  = 32;
  localparam int MAX_FONT_HEIGHT = 32;
  localparam int COORD_BITS      = 10;
  localparam int DIM_BITS        = 6;
  localparam int POS_BITS        = 5;
  localparam int COLOR_BITS      = 16;
  localparam int BYTE_BITS       = 8;
  localparam int PIX_IDX_BITS    = 3;
  localparam int CNT_BITS        = 4;
  localparam int CFG_IDX_BITS    = 2;
  localparam int CFG_DATA_BITS   = 16;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_AW         = $clog2(FIFO_DEPTH);

  localparam int IN_TDATA_BITS   = 32;
  localparam int OUT_TDATA_BITS  = 40;
  localparam int OUT_TUSER_BITS  = 2;

  typedef logic [COORD_BITS-1:0]   coord_t;
  typedef logic [DIM_BITS-1:0]     dim_t;
  typedef logic [POS_BITS-1:0]     pos_t;
  typedef logic [COLOR_BITS-1:0]   color_t;
  typedef logic [PIX_IDX_BITS-1:0] pix_idx_t;
  typedef logic [CNT_BITS-1:0]     cnt_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FONT_WIDTH       = 2'd0,
    REG_FONT_HEIGHT      = 2'd1,
    REG_BACKGROUND_COLOR = 2'd2,
    REG_FOREGROUND_COLOR = 2'd3
  } cfg_reg_e;

  // One classified byte: where its first pixel lands and how many pixels it makes.
  typedef struct packed {
    logic [BYTE_BITS-1:0] glyph_byte;
    coord_t               base_x;
    coord_t               y;
    pix_idx_t             n_m1;
    logic                 glyph_end;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

[rtl/core/bgpe_fifo.sv]
// Short register queue between the front and back parts of the expander.
// Depends on bgpe_pkg.
module bgpe_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  bgpe_pkg::rec_t       push_rec_i,
  input  logic                 pop_i,
  output bgpe_pkg::rec_t       head_o,
  output bgpe_pkg::fifo_stat_t stat_o
);

  bgpe_pkg::rec_t                 mem_q [bgpe_pkg::FIFO_DEPTH];
  logic [bgpe_pkg::FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [bgpe_pkg::FIFO_AW:0]     count_q;
  logic                           do_push, do_pop;

  assign stat_o.full  = (count_q == (bgpe_pkg::FIFO_AW + 1)'(bgpe_pkg::FIFO_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[rtl/core/bgpe_front.sv]
// Front part: tracks the pen and glyph position and classifies each byte.
// Depends on bgpe_pkg.
module bgpe_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic [bgpe_pkg::BYTE_BITS-1:0]      glyph_byte_i,
  input  logic                                string_start_i,
  input  bgpe_pkg::coord_t                    start_x_i,
  input  bgpe_pkg::coord_t                    start_y_i,
  input  bgpe_pkg::dim_t                      font_width_i,
  input  bgpe_pkg::dim_t                      font_height_i,
  output bgpe_pkg::rec_t                      rec_o
);

  bgpe_pkg::pos_t   column_base_q, column_base_d;
  bgpe_pkg::pos_t   row_index_q, row_index_d;
  bgpe_pkg::coord_t pen_x_q, pen_x_d;
  bgpe_pkg::coord_t pen_y_q, pen_y_d;

  bgpe_pkg::dim_t   w, h, col0, col1, row0, row1, row2, rem, col3, row_nxt;
  bgpe_pkg::coord_t px0, px1, py0;
  bgpe_pkg::cnt_t   n;

  always_comb begin
    // Zero counts as one, anything above the maximum as the maximum.
    if (font_width_i == '0) begin
      w = bgpe_pkg::dim_t'(1);
    end else if (font_width_i > bgpe_pkg::dim_t'(bgpe_pkg::MAX_FONT_WIDTH)) begin
      w = bgpe_pkg::dim_t'(bgpe_pkg::MAX_FONT_WIDTH);
    end else begin
      w = font_width_i;
    end
    if (font_height_i == '0) begin
      h = bgpe_pkg::dim_t'(1);
    end else if (font_height_i > bgpe_pkg::dim_t'(bgpe_pkg::MAX_FONT_HEIGHT)) begin
      h = bgpe_pkg::dim_t'(bgpe_pkg::MAX_FONT_HEIGHT);
    end else begin
      h = font_height_i;
    end

    if (string_start_i) begin
      px0  = start_x_i;
      py0  = start_y_i;
      col0 = '0;
      row0 = '0;
    end else begin
      px0  = pen_x_q;
      py0  = pen_y_q;
      col0 = bgpe_pkg::dim_t'(column_base_q);
      row0 = bgpe_pkg::dim_t'(row_index_q);
    end

    // The font may have shrunk since the last byte; finish the row or glyph first.
    if (col0 >= w) begin
      col1 = '0;
      row1 = row0 + 1'b1;
    end else begin
      col1 = col0;
      row1 = row0;
    end
    if (row1 >= h) begin
      row2 = '0;
      px1  = px0 + bgpe_pkg::coord_t'(w);
    end else begin
      row2 = row1;
      px1  = px0;
    end

    rem  = w - col1;
    n    = (rem > bgpe_pkg::dim_t'(bgpe_pkg::BYTE_BITS)) ?
           bgpe_pkg::cnt_t'(bgpe_pkg::BYTE_BITS) : bgpe_pkg::cnt_t'(rem);
    col3 = col1 + bgpe_pkg::dim_t'(n);
    row_nxt = row2 + 1'b1;

    rec_o.glyph_byte = glyph_byte_i;
    rec_o.base_x     = px1 + bgpe_pkg::coord_t'(col1);
    rec_o.y          = py0 + bgpe_pkg::coord_t'(row2);
    rec_o.n_m1       = bgpe_pkg::pix_idx_t'(n - 1'b1);
    rec_o.glyph_end  = (col3 == w) && (row_nxt == h);

    column_base_d = column_base_q;
    row_index_d   = row_index_q;
    pen_x_d       = pen_x_q;
    pen_y_d       = pen_y_q;
    if (accept_i) begin
      pen_y_d = py0;
      if (col3 >= w) begin
        column_base_d = '0;
        if (row_nxt >= h) begin
          row_index_d = '0;
          pen_x_d     = px1 + bgpe_pkg::coord_t'(w);
        end else begin
          row_index_d = bgpe_pkg::pos_t'(row_nxt);
          pen_x_d     = px1;
        end
      end else begin
        column_base_d = bgpe_pkg::pos_t'(col3);
        row_index_d   = bgpe_pkg::pos_t'(row2);
        pen_x_d       = px1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_base_q <= '0;
      row_index_q   <= '0;
      pen_x_q       <= '0;
      pen_y_q       <= '0;
    end else begin
      column_base_q <= column_base_d;
      row_index_q   <= row_index_d;
      pen_x_q       <= pen_x_d;
      pen_y_q       <= pen_y_d;
    end
  end

endmodule

[rtl/core/bgpe_back.sv]
// Back part: walks the bits of the queued byte and registers one pixel per cycle while the receiver does not stall.
// Depends on bgpe_pkg.
module bgpe_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bgpe_pkg::rec_t       head_i,
  input  bgpe_pkg::fifo_stat_t stat_i,
  output logic                 pop_o,
  output bgpe_pkg::pix_idx_t   pix_idx_o,
  input  bgpe_pkg::color_t     bg_color_i,
  input  bgpe_pkg::color_t     fg_color_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bgpe_pkg::coord_t     pixel_x_o,
  output bgpe_pkg::coord_t     pixel_y_o,
  output bgpe_pkg::color_t     pixel_color_o,
  output logic                 is_foreground_o,
  output logic                 last_of_byte_o,
  output logic                 glyph_done_o
);

  bgpe_pkg::pix_idx_t k_q, k_d;
  logic               valid_q, valid_d;
  logic               load, bit_val, last;

  assign load      = !stat_i.empty && (!valid_q || out_ready_i);
  // Bit 7 is the leftmost column, so pixel k takes bit 7 - k, which is ~k in three bits.
  assign bit_val   = head_i.glyph_byte[~k_q];
  assign last      = (k_q == head_i.n_m1);
  assign pop_o     = load && last;
  assign pix_idx_o = k_q;

  always_comb begin
    k_d     = k_q;
    valid_d = valid_q;
    if (out_ready_i) valid_d = 1'b0;
    if (load) begin
      valid_d = 1'b1;
      k_d     = last ? '0 : k_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      k_q     <= k_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pixel_x_o       <= head_i.base_x + bgpe_pkg::coord_t'(k_q);
      pixel_y_o       <= head_i.y;
      pixel_color_o   <= bit_val ? fg_color_i : bg_color_i;
      is_foreground_o <= bit_val;
      last_of_byte_o  <= last;
      glyph_done_o    <= last && head_i.glyph_end;
    end
  end

  assign out_valid_o = valid_q;

endmodule

[rtl/core/bitmap_glyph_pixel_expander.sv]
// Top level of the bitmap glyph pixel expander: configuration registers, stream ports,
// front part, byte queue and back part. Depends on bgpe_pkg, bgpe_front, bgpe_fifo, bgpe_back.
//
// Usage: each transaction on the slave stream carries one font bitmap byte of a glyph,
// in font-table order. s_axis_tuser_i is the string-start flag; when it is set the byte
// begins a new string and the start coordinates in tdata become the pen origin.
// Each byte expands into one to eight pixel transactions on the master stream, one per
// glyph column still left in the current row, most significant bit first. A set bit
// gives the foreground color, a clear bit the background color. m_axis_tlast_o marks
// the final pixel of a glyph; m_axis_tuser_o carries the foreground flag and the
// last-pixel-of-byte flag.
// With the queue empty, a byte that is taken goes into the queue, and its first pixel is
// registered in the pixel output register as soon as that register is free.
// Throughput: one pixel per cycle while the receiver does not stall; a byte holds the
// pixel stage until all its pixels have passed the single pixel output register.
// A four-entry queue separates byte intake from pixel output, so bytes keep being taken
// while pixels wait; when the receiver stalls the output holds and the queue fills,
// and then s_axis_tready_o drops.
// Reset clears the pen, the glyph position, the queue and the output valid, and loads
// width 17, height 24, background 0x0000 and foreground 0xFFFF.
// Configuration writes take effect at once and are to be made while the block is idle.
module bitmap_glyph_pixel_expander (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [bgpe_pkg::CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [bgpe_pkg::CFG_DATA_BITS-1:0]      cfg_data_i,
  input  logic                                    s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // tdata: glyph_byte [7:0], start_x [17:8], start_y [27:18], zero [31:28]
  input  logic [bgpe_pkg::IN_TDATA_BITS-1:0]      s_axis_tdata_i,
  // tuser: string_start
  input  logic                                    s_axis_tuser_i,
  output logic                                    m_axis_tvalid_o,
  input  logic                                    m_axis_tready_i,
  // tdata: pixel_x [9:0], pixel_y [19:10], pixel_color [35:20], zero [39:36]
  output logic [bgpe_pkg::OUT_TDATA_BITS-1:0]     m_axis_tdata_o,
  // tuser: is_foreground [0], last_of_byte [1]
  output logic [bgpe_pkg::OUT_TUSER_BITS-1:0]     m_axis_tuser_o,
  output logic                                    m_axis_tlast_o
);

  bgpe_pkg::dim_t       font_width_q, font_height_q;
  bgpe_pkg::color_t     bg_color_q, fg_color_q;
  bgpe_pkg::rec_t       push_rec, head;
  bgpe_pkg::fifo_stat_t stat;
  bgpe_pkg::pix_idx_t   pix_idx;
  bgpe_pkg::coord_t     pixel_x, pixel_y;
  bgpe_pkg::color_t     pixel_color;
  logic                 accept, pop, is_fg, last_of_byte, glyph_done;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      font_width_q  <= bgpe_pkg::dim_t'(17);
      font_height_q <= bgpe_pkg::dim_t'(24);
      bg_color_q    <= '0;
      fg_color_q    <= '1;
    end else if (cfg_we_i) begin
      case (bgpe_pkg::cfg_reg_e'(cfg_idx_i))
        bgpe_pkg::REG_FONT_WIDTH: begin
          font_width_q <= cfg_data_i[bgpe_pkg::DIM_BITS-1:0];
        end
        bgpe_pkg::REG_FONT_HEIGHT: begin
          font_height_q <= cfg_data_i[bgpe_pkg::DIM_BITS-1:0];
        end
        bgpe_pkg::REG_BACKGROUND_COLOR: begin
          bg_color_q <= cfg_data_i[bgpe_pkg::COLOR_BITS-1:0];
        end
        bgpe_pkg::REG_FOREGROUND_COLOR: begin
          fg_color_q <= cfg_data_i[bgpe_pkg::COLOR_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // A byte is taken whenever the queue has room.
  assign s_axis_tready_o = !stat.full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  bgpe_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .glyph_byte_i   (s_axis_tdata_i[7:0]),
    .string_start_i (s_axis_tuser_i),
    .start_x_i      (s_axis_tdata_i[17:8]),
    .start_y_i      (s_axis_tdata_i[27:18]),
    .font_width_i   (font_width_q),
    .font_height_i  (font_height_q),
    .rec_o          (push_rec)
  );

  bgpe_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (stat)
  );

  bgpe_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .stat_i          (stat),
    .pop_o           (pop),
    .pix_idx_o       (pix_idx),
    .bg_color_i      (bg_color_q),
    .fg_color_i      (fg_color_q),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .pixel_x_o       (pixel_x),
    .pixel_y_o       (pixel_y),
    .pixel_color_o   (pixel_color),
    .is_foreground_o (is_fg),
    .last_of_byte_o  (last_of_byte),
    .glyph_done_o    (glyph_done)
  );

  assign m_axis_tdata_o = {4'b0000, pixel_color, pixel_y, pixel_x};
  assign m_axis_tuser_o = {last_of_byte, is_fg};
  assign m_axis_tlast_o = glyph_done;

  // The end of a glyph always falls on the last pixel of a byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o[1])
    else $error("glyph end without end of byte");

  // The bit walk never runs past the pixel count of the byte at the queue head.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat.empty |-> pix_idx <= head.n_m1)
    else $error("pixel index beyond byte pixel count");

  // The bit walk sits at the first bit whenever no byte is queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.empty |-> pix_idx == '0)
    else $error("pixel index not cleared on empty queue");

endmodule

[tb/sv/bitmap_glyph_pixel_expander_test.sv]
// Self-checking testbench for bitmap_glyph_pixel_expander: streams glyph bitmap bytes,
// predicts every pixel write and compares the pixel stream field by field.
// Depends on bgpe_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module bitmap_glyph_pixel_expander_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_CAP   = 40;

  typedef struct {
    logic [7:0]       bits;
    logic             restart;
    bgpe_pkg::coord_t x;
    bgpe_pkg::coord_t y;
  } glyph_byte_t;

  typedef struct {
    bgpe_pkg::coord_t x;
    bgpe_pkg::coord_t y;
    bgpe_pkg::color_t color;
    logic             fg;
    logic             end_of_byte;
    logic             end_of_glyph;
  } pixel_write_t;

  // Block ports. Every input has a known value from time zero.
  logic                                clk_i           = 1'b0;
  logic                                rst_ni          = 1'b0;
  logic                                cfg_we_i        = 1'b0;
  logic [bgpe_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i       = '0;
  logic [bgpe_pkg::CFG_DATA_BITS-1:0]  cfg_data_i      = '0;
  logic                                s_axis_tvalid_i = 1'b0;
  logic                                s_axis_tready_o;
  // tdata: glyph_byte [7:0], start_x [17:8], start_y [27:18], zero [31:28]
  logic [bgpe_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata_i  = '0;
  // tuser: string_start
  logic                                s_axis_tuser_i  = 1'b0;
  logic                                m_axis_tvalid_o;
  logic                                m_axis_tready_i = 1'b0;
  // tdata: pixel_x [9:0], pixel_y [19:10], pixel_color [35:20], zero [39:36]
  logic [bgpe_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata_o;
  // tuser: is_foreground [0], last_of_byte [1]
  logic [bgpe_pkg::OUT_TUSER_BITS-1:0] m_axis_tuser_o;
  logic                                m_axis_tlast_o;

  // Shadow registers and glyph position that the pixel predictor works from.
  logic [bgpe_pkg::DIM_BITS-1:0] font_w;
  logic [bgpe_pkg::DIM_BITS-1:0] font_h;
  bgpe_pkg::color_t              bg_color;
  bgpe_pkg::color_t              fg_color;
  int                            col_base;
  int                            row_idx;
  bgpe_pkg::coord_t              pen_x;
  bgpe_pkg::coord_t              pen_y;

  glyph_byte_t  byte_queue[$];
  pixel_write_t pixel_queue[$];
  glyph_byte_t  held_byte;

  int bytes_queued     = 0;
  int bytes_taken      = 0;
  int pixels_seen      = 0;
  int glyphs_seen      = 0;
  int settings_used    = 0;
  int mismatch_count   = 0;
  int cycle_count      = 0;
  int src_gap          = 0;
  int sink_gap         = 0;
  bit calm             = 1'b0;

  bitmap_glyph_pixel_expander i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // A size of zero draws as one, anything above the maximum as the maximum.
  function automatic int fit_size(input logic [bgpe_pkg::DIM_BITS-1:0] v, input int cap);
    if (v == 0) return 1;
    if (int'(v) > cap) return cap;
    return int'(v);
  endfunction

  // Expands one accepted byte into the pixel writes it must produce.
  task automatic expand_byte(input glyph_byte_t b);
    int w;
    int h;
    int n;
    pixel_write_t px;
    w = fit_size(font_w, bgpe_pkg::MAX_FONT_WIDTH);
    h = fit_size(font_h, bgpe_pkg::MAX_FONT_HEIGHT);
    if (b.restart) begin
      pen_x    = b.x;
      pen_y    = b.y;
      col_base = 0;
      row_idx  = 0;
    end
    // A glyph size that shrank under a partly drawn glyph closes the row, and then
    // possibly the glyph, before this byte is drawn.
    if (col_base >= w) begin
      col_base = 0;
      row_idx++;
    end
    if (row_idx >= h) begin
      row_idx = 0;
      pen_x   = bgpe_pkg::coord_t'(int'(pen_x) + w);
    end
    n = (w - col_base > 8) ? 8 : w - col_base;
    for (int k = 0; k < n; k++) begin
      px.x            = bgpe_pkg::coord_t'(int'(pen_x) + col_base + k);
      px.y            = bgpe_pkg::coord_t'(int'(pen_y) + row_idx);
      px.fg           = b.bits[7-k];
      px.color        = px.fg ? fg_color : bg_color;
      px.end_of_byte  = (k == n - 1);
      px.end_of_glyph = px.end_of_byte && (col_base + n == w) && (row_idx + 1 == h);
      pixel_queue.push_back(px);
    end
    col_base += n;
    if (col_base >= w) begin
      col_base = 0;
      row_idx++;
      if (row_idx >= h) begin
        row_idx = 0;
        pen_x   = bgpe_pkg::coord_t'(int'(pen_x) + w);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < PRINT_CAP) begin
      $display("%0t: pixel %0d %s: got 0x%0h, expected 0x%0h",
               $realtime, pixels_seen, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic queue_byte(input logic [7:0] bits, input logic restart,
                            input bgpe_pkg::coord_t x, input bgpe_pkg::coord_t y);
    glyph_byte_t b;
    b.bits    = bits;
    b.restart = restart;
    b.x       = x;
    b.y       = y;
    byte_queue.push_back(b);
    bytes_queued++;
  endtask

  // Writes all four registers, one per clock, and mirrors them in the shadow copy.
  task automatic apply_setting(input logic [bgpe_pkg::CFG_DATA_BITS-1:0] w,
                               input logic [bgpe_pkg::CFG_DATA_BITS-1:0] h,
                               input bgpe_pkg::color_t bg, input bgpe_pkg::color_t fg);
    logic [bgpe_pkg::CFG_DATA_BITS-1:0] vals[4];
    bgpe_pkg::cfg_reg_e regs[4];
    vals = '{w, h, bg, fg};
    regs = '{bgpe_pkg::REG_FONT_WIDTH, bgpe_pkg::REG_FONT_HEIGHT,
             bgpe_pkg::REG_BACKGROUND_COLOR, bgpe_pkg::REG_FOREGROUND_COLOR};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= regs[i];
      cfg_data_i <= vals[i];
      case (regs[i])
        bgpe_pkg::REG_FONT_WIDTH:       font_w   = vals[i][bgpe_pkg::DIM_BITS-1:0];
        bgpe_pkg::REG_FONT_HEIGHT:      font_h   = vals[i][bgpe_pkg::DIM_BITS-1:0];
        bgpe_pkg::REG_BACKGROUND_COLOR: bg_color = vals[i];
        bgpe_pkg::REG_FOREGROUND_COLOR: fg_color = vals[i];
        default: ;
      endcase
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Every byte yields at least one pixel, so once all bytes are taken and no pixel is
  // outstanding the block is idle.
  task automatic wait_drained();
    while (bytes_taken != bytes_queued || pixel_queue.size() != 0) @(posedge clk_i);
  endtask

  // Source side: presents queued bytes, with random bursts of idle cycles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      bit slot_free;
      slot_free = !s_axis_tvalid_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expand_byte(held_byte);
        bytes_taken++;
        slot_free = 1'b1;
      end
      if (slot_free) begin
        if (src_gap > 0 && !calm) begin
          src_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (byte_queue.size() != 0) begin
          held_byte = byte_queue.pop_front();
          s_axis_tdata_i  <= {4'b0000, held_byte.y, held_byte.x, held_byte.bits};
          s_axis_tuser_i  <= held_byte.restart;
          s_axis_tvalid_i <= 1'b1;
          if ($urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 13);
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Sink side: checks every pixel transaction and stalls in random bursts.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      pixel_write_t want;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pixel_queue.size() == 0) begin
          report_mismatch("arrived with nothing expected", m_axis_tdata_o[9:0], 0);
        end else begin
          want = pixel_queue.pop_front();
          if (m_axis_tdata_o[9:0] !== want.x)
            report_mismatch("pixel_x", m_axis_tdata_o[9:0], want.x);
          if (m_axis_tdata_o[19:10] !== want.y)
            report_mismatch("pixel_y", m_axis_tdata_o[19:10], want.y);
          if (m_axis_tdata_o[35:20] !== want.color)
            report_mismatch("pixel_color", m_axis_tdata_o[35:20], want.color);
          if (m_axis_tuser_o[0] !== want.fg)
            report_mismatch("is_foreground", m_axis_tuser_o[0], want.fg);
          if (m_axis_tuser_o[1] !== want.end_of_byte)
            report_mismatch("last_of_byte", m_axis_tuser_o[1], want.end_of_byte);
          if (m_axis_tlast_o !== want.end_of_glyph)
            report_mismatch("glyph_done", m_axis_tlast_o, want.end_of_glyph);
        end
        if (m_axis_tlast_o === 1'b1) glyphs_seen++;
        pixels_seen++;
      end
      if (sink_gap > 0 && !calm) begin
        sink_gap--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if ($urandom_range(0, 11) == 0) sink_gap = $urandom_range(1, 13);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d pixels outstanding",
               cycle_count, pixel_queue.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int sel;
    logic [bgpe_pkg::CFG_DATA_BITS-1:0] w_val;
    logic [bgpe_pkg::CFG_DATA_BITS-1:0] h_val;
    logic [7:0] bits;
    logic restart;

    font_w   = 6'd17;
    font_h   = 6'd24;
    bg_color = 16'h0000;
    fg_color = 16'hFFFF;
    col_base = 0;
    row_idx  = 0;
    pen_x    = '0;
    pen_y    = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset font of 17 by 24: origin at the far corner so both coordinates wrap,
    // then a full row (8 + 8 + 1 pixels) and the start of the second row.
    queue_byte(8'hFF, 1'b1, 10'd1023, 10'd1023);
    queue_byte(8'h00, 1'b0, 10'd0, 10'd0);
    queue_byte(8'h5A, 1'b0, 10'd1023, 10'd1023);
    queue_byte(8'h3C, 1'b0, 10'd512, 10'd256);
    wait_drained();

    // Shrinking to 3 by 2 mid-row closes the row and the glyph before the next byte.
    apply_setting(16'd3, 16'd2, 16'hF800, 16'h07E0);
    queue_byte(8'hE0, 1'b0, 10'd0, 10'd0);
    queue_byte(8'h1F, 1'b0, 10'd0, 10'd0);
    queue_byte(8'hFF, 1'b0, 10'd0, 10'd0);
    queue_byte(8'h00, 1'b0, 10'd0, 10'd0);
    queue_byte(8'h80, 1'b1, 10'd0, 10'd0);
    wait_drained();

    // Zero sizes draw as one-pixel glyphs; the pen wraps past the right edge.
    apply_setting(16'd0, 16'd0, 16'hFFFF, 16'h0000);
    queue_byte(8'h80, 1'b1, 10'd1022, 10'd5);
    queue_byte(8'h7F, 1'b0, 10'd0, 10'd0);
    queue_byte(8'hFF, 1'b0, 10'd0, 10'd0);
    queue_byte(8'h01, 1'b0, 10'd0, 10'd0);
    wait_drained();

    // Oversized width and height are limited to the maximum of 32.
    apply_setting(16'd63, 16'd40, 16'h0000, 16'hFFFF);
    queue_byte(8'hFF, 1'b1, 10'd1000, 10'd1010);
    queue_byte(8'h00, 1'b0, 10'd0, 10'd0);
    queue_byte(8'hAA, 1'b0, 10'd0, 10'd0);
    queue_byte(8'h55, 1'b0, 10'd0, 10'd0);
    queue_byte(8'h96, 1'b0, 10'd0, 10'd0);
    wait_drained();

    // One row of full width: four bytes finish the glyph.
    apply_setting(16'd32, 16'd1, 16'h5555, 16'hAAAA);
    queue_byte(8'hFF, 1'b1, 10'd300, 10'd700);
    queue_byte(8'h00, 1'b0, 10'd0, 10'd0);
    queue_byte(8'h81, 1'b0, 10'd0, 10'd0);
    queue_byte(8'h7E, 1'b0, 10'd0, 10'd0);
    wait_drained();

    // Random part: mostly small fonts so that glyphs complete often, with the odd
    // extreme size. Phases end wherever they end, so size changes fall mid-glyph too.
    // The last phase runs without idling on either side.
    for (int p = 0; p < 6; p++) begin
      if (p == 5) calm = 1'b1;
      sel = $urandom_range(0, 9);
      case (sel)
        0:       w_val = 16'd0;
        1:       w_val = 16'd32;
        2:       w_val = 16'($urandom_range(33, 63));
        default: w_val = 16'($urandom_range(1, 12));
      endcase
      sel = $urandom_range(0, 9);
      case (sel)
        0:       h_val = 16'd0;
        1:       h_val = 16'd32;
        default: h_val = 16'($urandom_range(1, 4));
      endcase
      apply_setting(w_val, h_val, bgpe_pkg::color_t'($urandom),
                    bgpe_pkg::color_t'($urandom));
      for (int i = 0; i < 16; i++) begin
        sel = $urandom_range(0, 7);
        case (sel)
          0:       bits = 8'h00;
          1:       bits = 8'hFF;
          default: bits = 8'($urandom);
        endcase
        restart = (i == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, 15) == 0;
        queue_byte(bits, restart, bgpe_pkg::coord_t'($urandom),
                   bgpe_pkg::coord_t'($urandom));
      end
      wait_drained();
    end

    repeat (16) @(posedge clk_i);
    $display("Drove %0d glyph bytes under %0d register settings besides reset.",
             bytes_taken, settings_used);
    $display("Checked %0d pixel writes, %0d of them closing a glyph; %0d mismatches.",
             pixels_seen, glyphs_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/bgpe_pkg.sv
rtl/core/bgpe_fifo.sv
rtl/core/bgpe_front.sv
rtl/core/bgpe_back.sv
rtl/core/bitmap_glyph_pixel_expander.sv
tb/sv/bitmap_glyph_pixel_expander_test.sv
